@@ src/gas_pkg.sv @@
// ----------------------------------------------------------------------------
// gas_pkg
// Shared types and codes of the grid path search block.
// ----------------------------------------------------------------------------
package gas_pkg;

	localparam int GW    = 16;
	localparam int FW    = 18;
	localparam int CRD_W = 9;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	localparam logic [1:0] KIND_NORMAL = 2'd0;

	localparam logic [1:0] STAT_REACHED     = 2'd0;
	localparam logic [1:0] STAT_UNREACHABLE = 2'd1;
	localparam logic [1:0] STAT_OVERFLOW    = 2'd2;

	localparam logic REG_GRID_WIDTH  = 1'b0;
	localparam logic REG_GRID_HEIGHT = 1'b1;

	localparam int MARK_REACHED = 0;
	localparam int MARK_CLOSED  = 1;

	typedef struct packed {
		logic       opcode;
		logic [5:0] cell_x;
		logic [5:0] cell_y;
		logic [1:0] cell_kind;
		logic [5:0] start_x;
		logic [5:0] start_y;
		logic [5:0] target_x;
		logic [5:0] target_y;
	} gas_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [11:0] path_cost;
		logic [12:0] expanded_cells;
	} gas_res_t;

endpackage

@@ src/gas_if.sv @@
// ----------------------------------------------------------------------------
// gas channel interfaces
// Valid/ready channels for items, results and register writes.
// ----------------------------------------------------------------------------
interface gas_item_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [5:0] cell_x;
	logic [5:0] cell_y;
	logic [1:0] cell_kind;
	logic [5:0] start_x;
	logic [5:0] start_y;
	logic [5:0] target_x;
	logic [5:0] target_y;
	modport source (output valid, opcode, cell_x, cell_y, cell_kind, start_x, start_y,
		target_x, target_y, input ready);
	modport sink (input valid, opcode, cell_x, cell_y, cell_kind, start_x, start_y,
		target_x, target_y, output ready);
endinterface

interface gas_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [11:0] path_cost;
	logic [12:0] expanded_cells;
	modport source (output valid, status, path_cost, expanded_cells, input ready);
	modport sink (input valid, status, path_cost, expanded_cells, output ready);
endinterface

interface gas_cfg_if;
	logic       valid;
	logic       ready;
	logic       index;
	logic [6:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ src/grid_astar_path_search.sv @@
// a load transaction writes the cell store and leaves the block idle; a search first
// clears all 2^(clog2(MAX_WIDTH)+clog2(MAX_HEIGHT)) mark memory entries, then per expansion
// scans the open entries through the single read port of the open list and checks the
// neighbors; start off grid or start at target skip the clearing and go straight to the result
// one search at a time; arst_n clears the sequencer, output register and grid size (64x64)
// ----------------------------------------------------------------------------
// grid_astar_path_search
// Four-neighbor grid path search with a sequential open list scan.
// ----------------------------------------------------------------------------
module grid_astar_path_search #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64,
	parameter int OPEN_DEPTH = 4096
) (
	input  logic   clk,
	input  logic   arst_n,
	gas_item_if.sink     item,
	gas_result_if.source result,
	gas_cfg_if.sink      cfg
);
	localparam int CW = gas_pkg::CRD_W;
	localparam logic [CW-1:0] MW = CW'(MAX_WIDTH);
	localparam logic [CW-1:0] MH = CW'(MAX_HEIGHT);

	logic [6:0]          width_q, height_q;
	logic [CW-1:0]       w_clamp, h_clamp, w_ext, h_ext;
	logic                core_idle, core_res_valid, res_take, item_acc, out_valid_q;
	gas_pkg::gas_item_t  item_s;
	gas_pkg::gas_res_t   core_res, out_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 7'd64;
			height_q <= 7'd64;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				gas_pkg::REG_GRID_WIDTH:  width_q  <= cfg.data;
				gas_pkg::REG_GRID_HEIGHT: height_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		w_ext   = CW'(width_q);
		h_ext   = CW'(height_q);
		w_clamp = (w_ext == '0) ? CW'(1) : ((w_ext > MW) ? MW : w_ext);
		h_clamp = (h_ext == '0) ? CW'(1) : ((h_ext > MH) ? MH : h_ext);
	end

	assign item_s.opcode    = item.opcode;
	assign item_s.cell_x    = item.cell_x;
	assign item_s.cell_y    = item.cell_y;
	assign item_s.cell_kind = item.cell_kind;
	assign item_s.start_x   = item.start_x;
	assign item_s.start_y   = item.start_y;
	assign item_s.target_x  = item.target_x;
	assign item_s.target_y  = item.target_y;

	assign item.ready = core_idle;
	assign item_acc   = item.valid && core_idle;
	assign res_take   = core_res_valid && (!out_valid_q || result.ready);

	gas_search_core #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.OPEN_DEPTH (OPEN_DEPTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_acc  (item_acc),
		.item      (item_s),
		.w         (w_clamp),
		.h         (h_clamp),
		.idle      (core_idle),
		.res_valid (core_res_valid),
		.res       (core_res),
		.res_take  (res_take)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (res_take) begin
				out_valid_q <= 1'b1;
				out_q       <= core_res;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid          = out_valid_q;
	assign result.status         = out_q.status;
	assign result.path_cost      = out_q.path_cost;
	assign result.expanded_cells = out_q.expanded_cells;

`ifndef SYNTHESIS
	a_search_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready && item.opcode == gas_pkg::OP_SEARCH) |=> !item.ready)
		else $error("search transaction did not make the block busy");
	a_cost_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.status != gas_pkg::STAT_REACHED) |-> result.path_cost == '0)
		else $error("nonzero path cost without reaching the target");
	a_result_move: assert property (@(posedge clk) disable iff (!arst_n)
		(core_res_valid && !out_valid_q) |=> (out_valid_q && core_idle))
		else $error("finished result not moved to output register");
`endif
endmodule

@@ src/gas_cost_unit.sv @@
// ----------------------------------------------------------------------------
// gas_cost_unit
// Estimate unit of the open list scan: f = g + |x - tx| + |y - ty|.
// ----------------------------------------------------------------------------
module gas_cost_unit #(
	parameter int XW = 6,
	parameter int YW = 6
) (
	input  logic [gas_pkg::GW-1:0] g,
	input  logic [XW-1:0]          x,
	input  logic [YW-1:0]          y,
	input  logic [5:0]             tx,
	input  logic [5:0]             ty,
	output logic [gas_pkg::FW-1:0] f
);
	logic [gas_pkg::CRD_W-1:0] x9, y9, tx9, ty9, dx, dy;

	always_comb begin
		x9  = gas_pkg::CRD_W'(x);
		y9  = gas_pkg::CRD_W'(y);
		tx9 = gas_pkg::CRD_W'(tx);
		ty9 = gas_pkg::CRD_W'(ty);
		dx  = (x9 > tx9) ? x9 - tx9 : tx9 - x9;
		dy  = (y9 > ty9) ? y9 - ty9 : ty9 - y9;
		f   = gas_pkg::FW'(g) + gas_pkg::FW'(dx) + gas_pkg::FW'(dy);
	end
endmodule

@@ src/gas_search_core.sv @@
// ----------------------------------------------------------------------------
// gas_search_core
// Cell store, marks, cost and open list memories with the search sequencer.
// ----------------------------------------------------------------------------
module gas_search_core #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64,
	parameter int OPEN_DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_acc,
	input  gas_pkg::gas_item_t       item,
	input  logic [gas_pkg::CRD_W-1:0] w,
	input  logic [gas_pkg::CRD_W-1:0] h,
	output logic                     idle,
	output logic                     res_valid,
	output gas_pkg::gas_res_t        res,
	input  logic                     res_take
);
	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int YW    = $clog2(MAX_HEIGHT);
	localparam int AW    = XW + YW;
	localparam int CELLS = 1 << AW;
	localparam int OIW   = $clog2(OPEN_DEPTH);
	localparam int OW    = $clog2(OPEN_DEPTH + 1);
	localparam int EW    = AW + 1;
	localparam int ENW   = gas_pkg::GW + AW;
	localparam int CW    = gas_pkg::CRD_W;
	localparam logic [OW-1:0] OPEN_FULL = OW'(OPEN_DEPTH);
	localparam logic [CW-1:0] MW = CW'(MAX_WIDTH);
	localparam logic [CW-1:0] MH = CW'(MAX_HEIGHT);

	localparam logic [3:0] ST_IDLE      = 4'd0;
	localparam logic [3:0] ST_CLEAR     = 4'd1;
	localparam logic [3:0] ST_INIT      = 4'd2;
	localparam logic [3:0] ST_SCAN_RD   = 4'd3;
	localparam logic [3:0] ST_SCAN_CELL = 4'd4;
	localparam logic [3:0] ST_SCAN_EVAL = 4'd5;
	localparam logic [3:0] ST_EXPAND    = 4'd6;
	localparam logic [3:0] ST_G0        = 4'd7;
	localparam logic [3:0] ST_NB_RD     = 4'd8;
	localparam logic [3:0] ST_NB_EVAL   = 4'd9;
	localparam logic [3:0] ST_DONE      = 4'd10;

	logic [1:0]          kind_mem [CELLS];
	logic [1:0]          mark_mem [CELLS];
	logic [gas_pkg::GW-1:0] best_mem [CELLS];
	logic [ENW-1:0]      open_mem [OPEN_DEPTH];

	logic [1:0]          kind_rd_q, mark_rd_q;
	logic [gas_pkg::GW-1:0] best_rd_q;
	logic [ENW-1:0]      open_rd_q;

	logic                kind_we, mark_we, best_we, open_we, open_re, cell_re;
	logic [AW-1:0]       kind_wa, mark_wa, best_wa, cell_ra;
	logic [1:0]          kind_wd, mark_wd;
	logic [gas_pkg::GW-1:0] best_wd;
	logic [OIW-1:0]      open_wa, open_ra;
	logic [ENW-1:0]      open_wd;

	logic [3:0]          state_q;
	logic [AW-1:0]       clr_q, start_q, tcell_q, sel_q, n_q;
	logic [CW-1:0]       w_q, h_q;
	logic [5:0]          tx_q, ty_q;
	logic                tvalid_q, found_q;
	logic [OW-1:0]       i_q, k_q, cnt_q;
	logic [gas_pkg::FW-1:0] f_q, lowest_q, f_unit;
	logic [gas_pkg::GW-1:0] g0_q, ng;
	logic [2:0]          d_q;
	logic [EW-1:0]       exp_q;
	logic [1:0]          stat_q;
	logic [11:0]         cost_q;

	logic [XW-1:0]       e_x;
	logic [YW-1:0]       e_y;
	logic [AW-1:0]       e_cell, nb_cell;
	logic [gas_pkg::GW-1:0] e_g;
	logic                e_match, e_closed, nb_ok, push_ok;
	logic [CW-1:0]       sx9, sy9, nx9, ny9;
	logic [CW-1:0]       in_sx, in_sy, in_tx, in_ty;

	assign e_x      = open_rd_q[XW-1:0];
	assign e_y      = open_rd_q[AW-1:XW];
	assign e_cell   = open_rd_q[AW-1:0];
	assign e_g      = open_rd_q[ENW-1:AW];
	assign e_match  = tvalid_q && (e_cell == tcell_q);
	assign e_closed = mark_rd_q[gas_pkg::MARK_CLOSED];
	assign ng       = g0_q + gas_pkg::GW'(1);
	assign in_sx    = CW'(item.start_x);
	assign in_sy    = CW'(item.start_y);
	assign in_tx    = CW'(item.target_x);
	assign in_ty    = CW'(item.target_y);
	assign push_ok  = (kind_rd_q == gas_pkg::KIND_NORMAL) && !mark_rd_q[gas_pkg::MARK_CLOSED]
		&& !(mark_rd_q[gas_pkg::MARK_REACHED] && (ng >= best_rd_q));

	gas_cost_unit #(.XW(XW), .YW(YW)) u_cost (
		.g  (e_g),
		.x  (e_x),
		.y  (e_y),
		.tx (tx_q),
		.ty (ty_q),
		.f  (f_unit)
	);

	// neighbor order +x, +y, -x, -y
	always_comb begin
		sx9 = CW'(sel_q[XW-1:0]);
		sy9 = CW'(sel_q[AW-1:XW]);
		nx9 = sx9;
		ny9 = sy9;
		nb_ok = 1'b0;
		case (d_q[1:0])
			2'd0: begin
				nx9 = sx9 + CW'(1);
				nb_ok = nx9 < w_q;
			end
			2'd1: begin
				ny9 = sy9 + CW'(1);
				nb_ok = ny9 < h_q;
			end
			2'd2: begin
				nx9 = sx9 - CW'(1);
				nb_ok = sx9 != '0;
			end
			default: begin
				ny9 = sy9 - CW'(1);
				nb_ok = sy9 != '0;
			end
		endcase
		nb_cell = {YW'(ny9), XW'(nx9)};
	end

	always_comb begin
		kind_we = 1'b0;
		kind_wa = {YW'(item.cell_y), XW'(item.cell_x)};
		kind_wd = item.cell_kind;
		mark_we = 1'b0;
		mark_wa = clr_q;
		mark_wd = 2'b00;
		best_we = 1'b0;
		best_wa = n_q;
		best_wd = ng;
		open_we = 1'b0;
		open_wa = k_q[OIW-1:0];
		open_wd = open_rd_q;
		open_re = 1'b0;
		open_ra = i_q[OIW-1:0];
		cell_re = 1'b0;
		cell_ra = e_cell;
		unique case (state_q)
			ST_IDLE: begin
				kind_we = item_acc && (item.opcode == gas_pkg::OP_LOAD)
					&& (CW'(item.cell_x) < MW) && (CW'(item.cell_y) < MH);
			end
			ST_CLEAR: mark_we = 1'b1;
			ST_INIT: begin
				mark_we = 1'b1;
				mark_wa = start_q;
				mark_wd = 2'b01;
				best_we = 1'b1;
				best_wa = start_q;
				best_wd = '0;
				open_we = 1'b1;
				open_wa = '0;
				open_wd = {gas_pkg::GW'(0), start_q};
			end
			ST_SCAN_RD: open_re = (i_q != cnt_q);
			ST_SCAN_CELL: cell_re = 1'b1;
			ST_SCAN_EVAL: open_we = !e_closed;
			ST_EXPAND: begin
				mark_we = 1'b1;
				mark_wa = sel_q;
				mark_wd = 2'b11;
				cell_re = 1'b1;
				cell_ra = sel_q;
			end
			ST_G0: ;
			ST_NB_RD: begin
				cell_re = !d_q[2] && nb_ok;
				cell_ra = nb_cell;
			end
			ST_NB_EVAL: begin
				if (push_ok && (cnt_q < OPEN_FULL)) begin
					mark_we = 1'b1;
					mark_wa = n_q;
					mark_wd = 2'b01;
					best_we = 1'b1;
					open_we = 1'b1;
					open_wa = cnt_q[OIW-1:0];
					open_wd = {ng, n_q};
				end
			end
			ST_DONE: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (kind_we) kind_mem[kind_wa] <= kind_wd;
		if (mark_we) mark_mem[mark_wa] <= mark_wd;
		if (best_we) best_mem[best_wa] <= best_wd;
		if (open_we) open_mem[open_wa] <= open_wd;
		if (cell_re) begin
			kind_rd_q <= kind_mem[cell_ra];
			mark_rd_q <= mark_mem[cell_ra];
			best_rd_q <= best_mem[cell_ra];
		end
		if (open_re) open_rd_q <= open_mem[open_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			clr_q    <= '0;
			start_q  <= '0;
			tcell_q  <= '0;
			sel_q    <= '0;
			n_q      <= '0;
			w_q      <= '0;
			h_q      <= '0;
			tx_q     <= '0;
			ty_q     <= '0;
			tvalid_q <= 1'b0;
			found_q  <= 1'b0;
			i_q      <= '0;
			k_q      <= '0;
			cnt_q    <= '0;
			f_q      <= '0;
			lowest_q <= '0;
			g0_q     <= '0;
			d_q      <= '0;
			exp_q    <= '0;
			stat_q   <= gas_pkg::STAT_REACHED;
			cost_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (item_acc && (item.opcode == gas_pkg::OP_SEARCH)) begin
						w_q      <= w;
						h_q      <= h;
						tx_q     <= item.target_x;
						ty_q     <= item.target_y;
						tvalid_q <= (in_tx < w) && (in_ty < h);
						tcell_q  <= {YW'(item.target_y), XW'(item.target_x)};
						start_q  <= {YW'(item.start_y), XW'(item.start_x)};
						exp_q    <= '0;
						cost_q   <= '0;
						clr_q    <= '0;
						if ((in_sx >= w) || (in_sy >= h)) begin
							stat_q  <= gas_pkg::STAT_UNREACHABLE;
							state_q <= ST_DONE;
						end else if ((in_sx == in_tx) && (in_sy == in_ty)) begin
							stat_q  <= gas_pkg::STAT_REACHED;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_CLEAR;
						end
					end
				end
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == {AW{1'b1}}) state_q <= ST_INIT;
				end
				ST_INIT: begin
					cnt_q   <= OW'(1);
					i_q     <= '0;
					k_q     <= '0;
					found_q <= 1'b0;
					state_q <= ST_SCAN_RD;
				end
				ST_SCAN_RD: begin
					if (i_q == cnt_q) begin
						cnt_q <= k_q;
						if (found_q) begin
							state_q <= ST_EXPAND;
						end else begin
							stat_q  <= gas_pkg::STAT_UNREACHABLE;
							state_q <= ST_DONE;
						end
					end else begin
						state_q <= ST_SCAN_CELL;
					end
				end
				ST_SCAN_CELL: begin
					f_q     <= f_unit;
					state_q <= ST_SCAN_EVAL;
				end
				ST_SCAN_EVAL: begin
					i_q     <= i_q + OW'(1);
					state_q <= ST_SCAN_RD;
					if (!e_closed) begin
						k_q <= k_q + OW'(1);
						if (e_match) begin
							sel_q   <= e_cell;
							found_q <= 1'b1;
							state_q <= ST_EXPAND;
						end else if ((kind_rd_q == gas_pkg::KIND_NORMAL)
							&& (!found_q || (f_q <= lowest_q))) begin
							lowest_q <= f_q;
							sel_q    <= e_cell;
							found_q  <= 1'b1;
						end
					end
				end
				ST_EXPAND: begin
					exp_q   <= exp_q + EW'(1);
					state_q <= ST_G0;
				end
				ST_G0: begin
					if (tvalid_q && (sel_q == tcell_q)) begin
						stat_q  <= gas_pkg::STAT_REACHED;
						cost_q  <= 12'(best_rd_q);
						state_q <= ST_DONE;
					end else begin
						g0_q    <= best_rd_q;
						d_q     <= '0;
						state_q <= ST_NB_RD;
					end
				end
				ST_NB_RD: begin
					if (d_q[2]) begin
						i_q     <= '0;
						k_q     <= '0;
						found_q <= 1'b0;
						state_q <= ST_SCAN_RD;
					end else if (!nb_ok) begin
						d_q <= d_q + 3'd1;
					end else begin
						n_q     <= nb_cell;
						state_q <= ST_NB_EVAL;
					end
				end
				ST_NB_EVAL: begin
					d_q     <= d_q + 3'd1;
					state_q <= ST_NB_RD;
					if (push_ok) begin
						if (cnt_q >= OPEN_FULL) begin
							stat_q  <= gas_pkg::STAT_OVERFLOW;
							state_q <= ST_DONE;
						end else begin
							cnt_q <= cnt_q + OW'(1);
						end
					end
				end
				ST_DONE: begin
					if (res_take) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign idle               = (state_q == ST_IDLE);
	assign res_valid          = (state_q == ST_DONE);
	assign res.status         = stat_q;
	assign res.path_cost      = cost_q;
	assign res.expanded_cells = 13'(exp_q);
endmodule

@@ tb/grid_astar_path_search_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_astar_path_search_tb
// Drives grid loads, grid size writes and searches into the path search
// block, predicts each search outcome with a behavioral A* of its own, and
// compares every result transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module grid_astar_path_search_tb;

	localparam int CELLS     = 4096;
	localparam int OPEN_MAX  = 4096;
	localparam int ROW       = 64;
	localparam int IDLE_LIMIT = 200000;

	logic clk;
	logic arst_n;

	gas_item_if   item_ch();
	gas_result_if res_ch();
	gas_cfg_if    cfg_ch();

	grid_astar_path_search i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	logic [1:0]  kind_mem [CELLS];
	bit          closed_map [CELLS];
	bit          reached_map [CELLS];
	int          cost_map [CELLS];
	int unsigned open_list [$];
	int          grid_w = 64;
	int          grid_h = 64;

	gas_pkg::gas_res_t expected_results [$];
	int          mismatches = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          hold_left = 0;
	int          quiet_cycles = 0;
	int          loads_sent = 0;
	int          searches_sent = 0;
	int          status_seen [3] = '{0, 0, 0};

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic int absdiff(int a, int b);
		return a > b ? a - b : b - a;
	endfunction

	function automatic gas_pkg::gas_res_t search_outcome(int sx, int sy, int tx, int ty);
		int w, h, tcell, lowest, sel, g0, cx, cy, nx, ny, n, ng, c, f, expanded;
		bit tvalid, found;
		int unsigned kept [$];
		int dxs [4] = '{1, 0, -1, 0};
		int dys [4] = '{0, 1, 0, -1};
		gas_pkg::gas_res_t r;
		r = '0;
		w = grid_w < 1 ? 1 : (grid_w > ROW ? ROW : grid_w);
		h = grid_h < 1 ? 1 : (grid_h > ROW ? ROW : grid_h);
		foreach (closed_map[i]) begin
			closed_map[i] = 0;
			reached_map[i] = 0;
		end
		open_list.delete();
		expanded = 0;
		if (sx >= w || sy >= h) begin
			r.status = gas_pkg::STAT_UNREACHABLE;
			return r;
		end
		if (sx == tx && sy == ty) begin
			r.status = gas_pkg::STAT_REACHED;
			return r;
		end
		tvalid = (tx < w && ty < h);
		tcell = tvalid ? ty * ROW + tx : 0;
		c = sy * ROW + sx;
		cost_map[c] = 0;
		reached_map[c] = 1;
		open_list = {open_list, c};
		forever begin
			kept.delete();
			foreach (open_list[i])
				if (!closed_map[open_list[i] & 16'hFFFF]) kept = {kept, open_list[i]};
			open_list = kept;
			lowest = 32'h7FFFFFFF;
			sel = 0;
			found = 0;
			foreach (open_list[i]) begin
				c = open_list[i] & 16'hFFFF;
				f = (open_list[i] >> 16) + absdiff(c % ROW, tx) + absdiff(c / ROW, ty);
				if (f <= lowest && kind_mem[c] == gas_pkg::KIND_NORMAL) begin
					lowest = f;
					sel = c;
					found = 1;
				end
				if (tvalid && c == tcell) begin
					sel = c;
					found = 1;
					break;
				end
			end
			if (!found) begin
				r.status = gas_pkg::STAT_UNREACHABLE;
				r.expanded_cells = expanded[12:0];
				return r;
			end
			closed_map[sel] = 1;
			expanded++;
			if (tvalid && sel == tcell) begin
				r.status = gas_pkg::STAT_REACHED;
				r.path_cost = cost_map[sel][11:0];
				r.expanded_cells = expanded[12:0];
				return r;
			end
			g0 = cost_map[sel];
			cx = sel % ROW;
			cy = sel / ROW;
			for (int d = 0; d < 4; d++) begin
				nx = cx + dxs[d];
				ny = cy + dys[d];
				if (nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
				n = ny * ROW + nx;
				if (kind_mem[n] != gas_pkg::KIND_NORMAL || closed_map[n]) continue;
				ng = g0 + 1;
				if (reached_map[n] && ng >= cost_map[n]) continue;
				if (open_list.size() >= OPEN_MAX) begin
					r.status = gas_pkg::STAT_OVERFLOW;
					r.expanded_cells = expanded[12:0];
					return r;
				end
				cost_map[n] = ng;
				reached_map[n] = 1;
				open_list = {open_list, int'(n | ((ng & 16'hFFFF) << 16))};
			end
		end
	endfunction

	function automatic void apply_item(gas_pkg::gas_item_t it);
		if (it.opcode == gas_pkg::OP_LOAD) begin
			kind_mem[{it.cell_y, it.cell_x}] = it.cell_kind;
			loads_sent++;
		end else begin
			expected_results = {expected_results, search_outcome(int'(it.start_x),
				int'(it.start_y), int'(it.target_x), int'(it.target_y))};
			searches_sent++;
		end
	endfunction

	// leaves valid high; the next call either keeps it up or drops it
	task automatic send_item(gas_pkg::gas_item_t it);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid     <= 1'b1;
		item_ch.opcode    <= it.opcode;
		item_ch.cell_x    <= it.cell_x;
		item_ch.cell_y    <= it.cell_y;
		item_ch.cell_kind <= it.cell_kind;
		item_ch.start_x   <= it.start_x;
		item_ch.start_y   <= it.start_y;
		item_ch.target_x  <= it.target_x;
		item_ch.target_y  <= it.target_y;
		do @(posedge clk); while (!item_ch.ready);
		apply_item(it);
	endtask

	task automatic send_load(int x, int y, logic [1:0] k);
		gas_pkg::gas_item_t it;
		it = '0;
		it.opcode = gas_pkg::OP_LOAD;
		it.cell_x = 6'(x);
		it.cell_y = 6'(y);
		it.cell_kind = k;
		it.start_x = 6'($urandom);
		it.target_y = 6'($urandom);
		send_item(it);
	endtask

	task automatic send_search(int sx, int sy, int tx, int ty);
		gas_pkg::gas_item_t it;
		it = '0;
		it.opcode = gas_pkg::OP_SEARCH;
		it.start_x = 6'(sx);
		it.start_y = 6'(sy);
		it.target_x = 6'(tx);
		it.target_y = 6'(ty);
		it.cell_x = 6'($urandom);
		it.cell_kind = 2'($urandom);
		send_item(it);
	endtask

	task automatic wait_drain();
		item_ch.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [6:0] value);
		wait_drain();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		if (idx == gas_pkg::REG_GRID_WIDTH) grid_w = int'(value);
		else grid_h = int'(value);
	endtask

	task automatic set_grid(int w, int h);
		write_reg(gas_pkg::REG_GRID_WIDTH, 7'(w));
		write_reg(gas_pkg::REG_GRID_HEIGHT, 7'(h));
	endtask

	task automatic test_reset_size();
		send_search(5, 7, 5, 7);
		send_search(63, 63, 63, 63);
		send_search(0, 0, 0, 0);
	endtask

	task automatic test_directed();
		set_grid(0, 0);
		send_load(0, 0, 2'd0);
		send_search(0, 0, 9, 9);
		send_search(1, 0, 0, 0);
		set_grid(127, 127);
		send_search(63, 0, 63, 0);
		set_grid(4, 3);
		for (int y = 0; y < 3; y++)
			for (int x = 0; x < 4; x++)
				send_load(x, y, (y == 1 && x == 1) ? 2'd1 : (y == 1 && x == 2) ? 2'd2 :
					(y == 2 && x == 3) ? 2'd3 : 2'd0);
		send_load(63, 63, 2'd3);
		send_search(0, 0, 3, 0);
		send_search(0, 0, 2, 2);
		send_search(1, 1, 0, 0);
		send_search(0, 0, 3, 2);
		send_search(3, 0, 0, 2);
		send_search(0, 2, 40, 1);
	endtask

	function automatic logic [1:0] random_kind();
		return ($urandom_range(0, 99) < 70) ? 2'd0 : 2'($urandom_range(1, 3));
	endfunction

	task automatic fill_search_area();
		for (int y = 0; y < 8; y++)
			for (int x = 0; x < 8; x++)
				send_load(x, y, random_kind());
	endtask

	task automatic test_random(int s_pct, int r_pct, int n);
		int w, h;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		for (int p = 0; p < 2; p++) begin
			w = $urandom_range(1, 8);
			h = $urandom_range(2, 8);
			set_grid(w, h);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 99) < 70) begin
					if ($urandom_range(0, 99) < 85)
						send_search($urandom_range(0, w - 1), $urandom_range(0, h - 1),
							($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) :
							$urandom_range(0, w - 1), $urandom_range(0, h - 1));
					else
						send_search($urandom_range(0, 63), $urandom_range(0, 63),
							$urandom_range(0, 63), $urandom_range(0, 63));
				end else if ($urandom_range(0, 3) != 0) begin
					send_load($urandom_range(0, 7), $urandom_range(0, 7), random_kind());
				end else begin
					send_load($urandom_range(0, 63), $urandom_range(0, 63), 2'($urandom));
				end
			end
		end
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_grid(8, 8);
		hold_left = 20000;
		for (int i = 0; i < 4; i++)
			send_search($urandom_range(0, 7), $urandom_range(0, 7),
				$urandom_range(0, 7), $urandom_range(0, 7));
		wait_drain();
		send_search(0, 0, 7, 7);
		send_search(7, 7, 0, 0);
	endtask

	always @(posedge clk) begin
		gas_pkg::gas_res_t got, want;
		if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready) || hold_left > 0)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
			$display("grid_astar_path_search regression: fail");
			$finish;
		end
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got.status = res_ch.status;
			got.path_cost = res_ch.path_cost;
			got.expanded_cells = res_ch.expanded_cells;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transaction %p", got);
			end else begin
				want = expected_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", want, got);
				end
				if (want.status <= gas_pkg::STAT_OVERFLOW) status_seen[want.status]++;
			end
		end
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	initial begin
		foreach (kind_mem[i]) kind_mem[i] = '0;
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.opcode = gas_pkg::OP_LOAD;
		item_ch.cell_x = '0;
		item_ch.cell_y = '0;
		item_ch.cell_kind = '0;
		item_ch.start_x = '0;
		item_ch.start_y = '0;
		item_ch.target_x = '0;
		item_ch.target_y = '0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = gas_pkg::REG_GRID_WIDTH;
		cfg_ch.data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_size();
		test_directed();
		send_idle_pct = 32;
		recv_idle_pct = 86;
		fill_search_area();
		test_random(32, 86, 7);
		test_random(86, 32, 7);
		test_random(0, 0, 7);
		test_backpressure();
		wait_drain();
		$display("covered %0d loads and %0d searches over grid sizes 1x1 to 64x64",
			loads_sent, searches_sent);
		$display("outcomes: %0d reached, %0d unreachable, %0d overflow; %0d mismatches",
			status_seen[0], status_seen[1], status_seen[2], mismatches);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("grid_astar_path_search regression: pass");
		else
			$display("grid_astar_path_search regression: fail");
		$finish;
	end

endmodule
